FILE: src/mtdb_pkg.sv
// Package for the morph target delta blend unit.
// Holds sizes, command and register codes, and the structs shared between modules.
// No dependencies.
`default_nettype none
package mtdb_pkg;

	localparam int MAX_VERTICES   = 1024;
	localparam int NUM_TARGETS    = 4;
	localparam int NUM_ATTRIBUTES = 3;

	localparam int COMP_W    = 32;
	localparam int WEIGHT_W  = 16;
	localparam int VCOUNT_W  = 11;
	localparam int VERTEX_W  = 16;
	localparam int LIMIT_W   = VERTEX_W + 1;
	localparam int VTX_IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int STORE_DEPTH = NUM_ATTRIBUTES * MAX_VERTICES;
	localparam int ADDR_W    = $clog2(STORE_DEPTH);
	localparam int ENTRY_W   = 3 * COMP_W;

	localparam int NUM_WEIGHT_REGS = 4;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_ACC  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_0     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_1     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_2     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_3     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd4;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;

	typedef logic signed [WEIGHT_W-1:0] weight_t;
	typedef logic signed [COMP_W-1:0] comp_t;

	typedef struct packed {
		weight_t [NUM_WEIGHT_REGS-1:0] weight;
		logic [VCOUNT_W-1:0]           vertex_count;
	} cfg_t;

	typedef struct packed {
		logic [1:0]          command;
		logic [1:0]          attribute;
		logic [VERTEX_W-1:0] vertex;
		logic [1:0]          target_slot;
		comp_t               comp_x;
		comp_t               comp_y;
		comp_t               comp_z;
	} in_item_t;

	typedef struct packed {
		logic capture;
		logic issue_read;
		logic execute;
		logic push;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

FILE: src/mtdb_in_if.sv
// Request channel of the blend unit: valid/ready plus one command beat.
// Uses mtdb_pkg for field widths.
`default_nettype none
interface mtdb_in_if
	import mtdb_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [1:0]          command;
	logic [1:0]          attribute;
	logic [VERTEX_W-1:0] vertex;
	logic [1:0]          target_slot;
	comp_t               comp_x;
	comp_t               comp_y;
	comp_t               comp_z;

	modport source (output valid, command, attribute, vertex, target_slot,
		comp_x, comp_y, comp_z, input ready);
	modport sink (input valid, command, attribute, vertex, target_slot,
		comp_x, comp_y, comp_z, output ready);
endinterface
`default_nettype wire

FILE: src/mtdb_out_if.sv
// Response channel of the blend unit: valid/ready plus one result beat.
// Uses mtdb_pkg for field widths.
`default_nettype none
interface mtdb_out_if
	import mtdb_pkg::*;
	();
	logic  valid;
	logic  ready;
	comp_t out_x;
	comp_t out_y;
	comp_t out_z;
	logic  index_valid;
	logic  saturated;

	modport source (output valid, out_x, out_y, out_z, index_valid, saturated,
		input ready);
	modport sink (input valid, out_x, out_y, out_z, index_valid, saturated,
		output ready);
endinterface
`default_nettype wire

FILE: src/mtdb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mtdb_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 3072
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/mtdb_cfg.sv
// APB-style register block: four target weights and the vertex count.
// Depends on mtdb_pkg.
`default_nettype none
module mtdb_cfg
	import mtdb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	cfg_t                 cfg_q;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weight       <= '0;
			cfg_q.vertex_count <= VCOUNT_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_WEIGHT_0:     cfg_q.weight[0] <= pwdata[WEIGHT_W-1:0];
				REG_WEIGHT_1:     cfg_q.weight[1] <= pwdata[WEIGHT_W-1:0];
				REG_WEIGHT_2:     cfg_q.weight[2] <= pwdata[WEIGHT_W-1:0];
				REG_WEIGHT_3:     cfg_q.weight[3] <= pwdata[WEIGHT_W-1:0];
				REG_VERTEX_COUNT: cfg_q.vertex_count <= pwdata[VCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WEIGHT_0:     prdata = {{(PDATA_W-WEIGHT_W){1'b0}}, cfg_q.weight[0]};
			REG_WEIGHT_1:     prdata = {{(PDATA_W-WEIGHT_W){1'b0}}, cfg_q.weight[1]};
			REG_WEIGHT_2:     prdata = {{(PDATA_W-WEIGHT_W){1'b0}}, cfg_q.weight[2]};
			REG_WEIGHT_3:     prdata = {{(PDATA_W-WEIGHT_W){1'b0}}, cfg_q.weight[3]};
			REG_VERTEX_COUNT: prdata = {{(PDATA_W-VCOUNT_W){1'b0}}, cfg_q.vertex_count};
			default:          prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: src/mtdb_ctrl.sv
// Sequencer for one command: capture, store read, execute/write-back, hand-off.
// Depends on mtdb_pkg.
`default_nettype none
module mtdb_ctrl
	import mtdb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  dp_status_t      st,
	output ctrl_cmd_t       cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;
	localparam logic [1:0] S_PUSH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_READ;
				end
			end
			S_READ: begin
				cmd.issue_read = 1'b1;
				state_d        = S_EXEC;
			end
			S_EXEC: begin
				cmd.execute = 1'b1;
				state_d     = S_PUSH;
			end
			S_PUSH: begin
				if (st.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_READ))
		else $error("accepted beat did not start a store read");

	a_read_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (state_q == S_EXEC))
		else $error("store read not followed by execute");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> st.out_free)
		else $error("result pushed into occupied output register");

endmodule
`default_nettype wire

FILE: src/mtdb_dp.sv
// Datapath: input capture, weight multiply, attribute store, saturating add, output register.
// Depends on mtdb_pkg, mtdb_ram and mtdb_out_if.
`default_nettype none
module mtdb_dp
	import mtdb_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  ctrl_cmd_t   cmd,
	output dp_status_t  st,
	input  cfg_t        cfg,
	input  in_item_t    item,
	mtdb_out_if.source  rsp
);

	localparam int PROD_W   = WEIGHT_W + COMP_W;
	localparam int ROUND_W  = PROD_W + 1;
	localparam int SCALED_W = ROUND_W - 12;
	localparam int SUM_W    = SCALED_W + 1;

	typedef struct packed {
		comp_t value;
		logic  clip;
	} sat_t;

	function automatic sat_t sat_add(input comp_t entry, input logic signed [SCALED_W-1:0] d);
		logic signed [SUM_W-1:0] s;
		sat_t r;
		s = SUM_W'(entry) + SUM_W'(d);
		if (s[SUM_W-1:COMP_W-1] == '0 || s[SUM_W-1:COMP_W-1] == '1) begin
			r.value = s[COMP_W-1:0];
			r.clip  = 1'b0;
		end else begin
			r.value = s[SUM_W-1] ? {1'b1, {(COMP_W-1){1'b0}}} : {1'b0, {(COMP_W-1){1'b1}}};
			r.clip  = 1'b1;
		end
		return r;
	endfunction

	// capture stage
	logic [1:0]        command_q;
	comp_t             comp_q [3];
	weight_t           w_q;
	logic              idx_ok_q;
	logic [ADDR_W-1:0] addr_q;

	logic [LIMIT_W-1:0] limit;
	logic               idx_ok;
	weight_t            w_sel;

	assign limit = (LIMIT_W'(cfg.vertex_count) < LIMIT_W'(MAX_VERTICES)) ?
		LIMIT_W'(cfg.vertex_count) : LIMIT_W'(MAX_VERTICES);
	assign idx_ok = (3'(item.attribute) < 3'(NUM_ATTRIBUTES)) &&
		(LIMIT_W'(item.vertex) < limit);
	assign w_sel = (3'(item.target_slot) < 3'(NUM_TARGETS)) ?
		cfg.weight[item.target_slot] : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			command_q <= item.command;
			comp_q[0] <= item.comp_x;
			comp_q[1] <= item.comp_y;
			comp_q[2] <= item.comp_z;
			w_q       <= w_sel;
			idx_ok_q  <= idx_ok;
			addr_q    <= ADDR_W'(item.attribute) * ADDR_W'(MAX_VERTICES) +
				ADDR_W'(item.vertex[VTX_IDX_W-1:0]);
		end
	end

	// multiply, alongside the store read
	logic signed [PROD_W-1:0] prod_q [3];

	always_ff @(posedge clk) begin
		if (cmd.issue_read) begin
			for (int k = 0; k < 3; k++) begin
				prod_q[k] <= PROD_W'(w_q) * PROD_W'(comp_q[k]);
			end
		end
	end

	// store
	logic               ram_we;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	mtdb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.re    (cmd.issue_read),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// execute
	logic  acc_en;
	logic  load_en;
	comp_t new_val [3];
	logic  clip    [3];
	logic  any_clip;

	assign acc_en  = idx_ok_q && (command_q == CMD_ACC) && (w_q != '0);
	assign load_en = idx_ok_q && (command_q == CMD_LOAD);

	always_comb begin
		logic signed [ROUND_W-1:0]  rnd;
		logic signed [SCALED_W-1:0] scaled;
		sat_t                       r;
		for (int k = 0; k < 3; k++) begin
			rnd    = ROUND_W'(prod_q[k]) + ROUND_W'(2048);
			scaled = rnd[ROUND_W-1:12];
			r      = sat_add(ram_rdata[k*COMP_W +: COMP_W], scaled);
			if (load_en) begin
				new_val[k] = comp_q[k];
				clip[k]    = 1'b0;
			end else if (acc_en) begin
				new_val[k] = r.value;
				clip[k]    = r.clip;
			end else begin
				new_val[k] = ram_rdata[k*COMP_W +: COMP_W];
				clip[k]    = 1'b0;
			end
		end
	end

	assign any_clip  = clip[0] | clip[1] | clip[2];
	assign ram_wdata = {new_val[2], new_val[1], new_val[0]};
	assign ram_we    = cmd.execute && (load_en || acc_en);

	comp_t res_q [3];
	logic  res_idx_ok_q;
	logic  res_sat_q;

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			for (int k = 0; k < 3; k++) begin
				res_q[k] <= idx_ok_q ? new_val[k] : '0;
			end
			res_idx_ok_q <= idx_ok_q;
			res_sat_q    <= idx_ok_q && any_clip;
		end
	end

	// output register
	logic out_valid_q;

	assign st.out_free = !out_valid_q || rsp.ready;
	assign rsp.valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			rsp.out_x       <= res_q[0];
			rsp.out_y       <= res_q[1];
			rsp.out_z       <= res_q[2];
			rsp.index_valid <= res_idx_ok_q;
			rsp.saturated   <= res_sat_q;
		end
	end

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> rsp.valid)
		else $error("pushed result not presented on the response channel");

endmodule
`default_nettype wire

FILE: src/morph_target_delta_blend_unit.sv
// Top level of the morph target delta blend unit.
// Depends on mtdb_pkg, mtdb_in_if, mtdb_out_if, mtdb_cfg, mtdb_ctrl, mtdb_dp, mtdb_ram.
`default_nettype none
// Each request beat (load, accumulate or read) addresses one xyz entry of a
// 3 x MAX_VERTICES store of Q16.16 vectors and produces exactly one response
// beat holding the entry as it stands afterwards. Accumulate adds the delta
// scaled by the chosen Q4.12 target weight, rounded half up, with per-component
// 32-bit saturation. Vertices at or beyond the vertex count, and attribute
// code 3, leave the store alone and answer with zeros and index_valid low.
// Commands run one at a time: an item passes from acceptance to its response
// beat being presented through capture, store read with the weight multiply
// alongside, execute with write-back, and hand-off, the registered read of the
// single store RAM coming ahead of the read-modify-write; a new request is taken
// the cycle after hand-off, so no new item enters before the last is through,
// and a response stall that keeps the output register full holds the next one up.
// The store is not cleared at reset: an entry must be loaded before it is read or
// accumulated. The user must write weights and vertex count over the APB port
// only while the unit is idle; the block itself does not enforce this.
module morph_target_delta_blend_unit
	import mtdb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	mtdb_in_if.sink                 req,
	mtdb_out_if.source              rsp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	cfg_t       cfg;
	ctrl_cmd_t  cmd;
	dp_status_t st;
	in_item_t   item;

	// request payload gathered into one struct for the datapath
	assign item.command     = req.command;
	assign item.attribute   = req.attribute;
	assign item.vertex      = req.vertex;
	assign item.target_slot = req.target_slot;
	assign item.comp_x      = req.comp_x;
	assign item.comp_y      = req.comp_y;
	assign item.comp_z      = req.comp_z;

	mtdb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: takes a beat only when idle
	mtdb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath owns the store and the response register
	mtdb_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.st     (st),
		.cfg    (cfg),
		.item   (item),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire
